// ----- hw/rtl/mco_pkg.sv -----
package mco_pkg;

	localparam int SIDE_W  = 4;
	localparam int COST_W  = 52;
	localparam int DIM_W   = 16;
	localparam int STACK_D = 32;
	localparam int STACK_AW = 5;
	localparam int CNT_W   = 6;

	typedef enum logic [2:0] {
		TK_MATRIX = 3'd0,
		TK_OPEN   = 3'd1,
		TK_TIMES  = 3'd2,
		TK_CLOSE  = 3'd3,
		TK_COST   = 3'd4,
		TK_ERROR  = 3'd5
	} tok_kind_t;

	typedef enum logic [1:0] {
		PH_OPEN  = 2'd0,
		PH_TIMES = 2'd1,
		PH_CLOSE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		T_LOAD,
		T_FILL,
		T_WALK
	} top_state_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_RDI,
		F_RDJ,
		F_MUL1,
		F_KRD,
		F_KMUL,
		F_KADD,
		F_WR
	} fill_state_t;

	typedef enum logic [2:0] {
		W_IDLE,
		W_ERR,
		W_COST,
		W_RD,
		W_EM
	} walk_state_t;

	typedef struct packed {
		logic              go;
		logic              err;
		logic [COST_W-1:0] cost;
		logic [SIDE_W-1:0] last;
	} walk_cmd_t;

endpackage

// ----- hw/rtl/mco_fill.sv -----
module mco_fill #(
	parameter int MAX_MATRICES = 16,
	parameter int AW = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        dim_we,
	input  logic [AW-1:0]               dim_waddr,
	input  logic [mco_pkg::DIM_W-1:0]   dim_wdata,
	input  logic                        start,
	input  logic [mco_pkg::SIDE_W-1:0]  n_last,
	output logic                        done,
	output logic [mco_pkg::COST_W-1:0]  best_cost,
	input  logic [2*mco_pkg::SIDE_W-1:0] sp_raddr,
	output logic [mco_pkg::SIDE_W-1:0]  sp_rdata
);
	import mco_pkg::*;

	localparam int DEPTH = MAX_MATRICES + 1;

	logic [DIM_W-1:0]  dims_mem [DEPTH];
	logic [COST_W-1:0] cost_mem [256];
	logic [SIDE_W-1:0] split_mem [256];

	fill_state_t state_q, state_d;

	logic [4:0]          len_q;
	logic [SIDE_W-1:0]   i_q, k_q, last_q, where_q;
	logic [DIM_W-1:0]    di_q, dim_rd_q;
	logic [31:0]         p1_q;
	logic [47:0]         prod_q;
	logic [COST_W-1:0]   ca_q, cb_q, ca_rd_q, cb_rd_q, best_q;
	logic [SIDE_W-1:0]   sp_rd_q;

	logic [SIDE_W-1:0]   j_w, k1_w;
	logic [4:0]          dim_ra_w;
	logic [COST_W-1:0]   sum_w;
	logic                last_k_w, next_i_w, fin_w;

	assign j_w      = i_q + len_q[SIDE_W-1:0] - 4'd1;
	assign k1_w     = k_q + 4'd1;
	assign sum_w    = ca_q + cb_q + {4'b0, prod_q};
	assign last_k_w = (k1_w == j_w);
	assign next_i_w = ({1'b0, i_q} + len_q) <= {1'b0, last_q};
	assign fin_w    = (len_q == ({1'b0, last_q} + 5'd1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: if (start) state_d = F_RDI;
			F_RDI:  state_d = F_RDJ;
			F_RDJ:  state_d = F_MUL1;
			F_MUL1: state_d = F_KRD;
			F_KRD:  state_d = F_KMUL;
			F_KMUL: state_d = F_KADD;
			F_KADD: state_d = last_k_w ? F_WR : F_KRD;
			F_WR:   state_d = (!next_i_w && fin_w) ? F_IDLE : F_RDI;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			F_RDI:   dim_ra_w = {1'b0, i_q};
			F_RDJ:   dim_ra_w = {1'b0, j_w} + 5'd1;
			F_KRD:   dim_ra_w = {1'b0, k1_w};
			default: dim_ra_w = {1'b0, i_q};
		endcase
		done = (state_q == F_WR) && !next_i_w && fin_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (dim_we) begin
			dims_mem[dim_waddr] <= dim_wdata;
		end
		dim_rd_q <= dims_mem[dim_ra_w[AW-1:0]];
		ca_rd_q  <= cost_mem[{i_q, k_q}];
		cb_rd_q  <= cost_mem[{k1_w, j_w}];
		sp_rd_q  <= split_mem[sp_raddr];
		if (state_q == F_WR) begin
			cost_mem[{i_q, j_w}]  <= best_q;
			split_mem[{i_q, j_w}] <= where_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (start) begin
					len_q  <= 5'd2;
					i_q    <= '0;
					last_q <= n_last;
				end
			end
			F_RDI: begin
				k_q     <= i_q;
				best_q  <= '1;
				where_q <= i_q;
			end
			F_RDJ:  di_q <= dim_rd_q;
			F_MUL1: p1_q <= di_q * dim_rd_q;
			F_KMUL: begin
				prod_q <= p1_q * dim_rd_q;
				// diagonal entries are never stored: they cost nothing
				ca_q   <= (k_q == i_q) ? '0 : ca_rd_q;
				cb_q   <= (k1_w == j_w) ? '0 : cb_rd_q;
			end
			F_KADD: begin
				if (best_q >= sum_w) begin
					best_q  <= sum_w;
					where_q <= k_q;
				end
				k_q <= k1_w;
			end
			F_WR: begin
				if (next_i_w) begin
					i_q <= i_q + 4'd1;
				end else if (!fin_w) begin
					i_q   <= '0;
					len_q <= len_q + 5'd1;
				end
			end
			default: ;
		endcase
	end

	assign best_cost = best_q;
	assign sp_rdata  = sp_rd_q;

endmodule

// ----- hw/rtl/mco_walk.sv -----
module mco_walk (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mco_pkg::walk_cmd_t           cmd,
	output logic                         done,
	output logic [2*mco_pkg::SIDE_W-1:0] sp_raddr,
	input  logic [mco_pkg::SIDE_W-1:0]   sp_rdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [55:0]                  m_tdata,  // token_value
	output logic [2:0]                   m_tuser,  // token_kind
	output logic                         m_tlast
);
	import mco_pkg::*;

	logic [9:0] stack_mem [STACK_D];

	walk_state_t state_q, state_d;

	logic [COST_W-1:0] cost_q;
	logic [SIDE_W-1:0] ti_q, tj_q;
	logic [1:0]        tph_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [9:0]        st_rd_q;

	logic              ovalid_q, olast_q;
	tok_kind_t         okind_q;
	logic [COST_W-1:0] oval_q;

	logic              free_w, load_w, last_w, pop_w, push_w;
	tok_kind_t         kind_w;
	logic [COST_W-1:0] val_w;
	logic [CNT_W-1:0]  rd_a_w, wr_a_w;

	assign free_w   = !ovalid_q || m_tready;
	assign rd_a_w   = cnt_q - 6'd2;
	assign wr_a_w   = cnt_q - 6'd1;
	assign sp_raddr = {ti_q, tj_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			W_IDLE: begin
				if (cmd.err) state_d = W_ERR;
				else if (cmd.go) state_d = W_COST;
			end
			W_ERR:  if (free_w) state_d = W_IDLE;
			W_COST: if (free_w) state_d = W_RD;
			W_RD:   state_d = W_EM;
			W_EM:   if (free_w) state_d = last_w ? W_IDLE : W_RD;
			default: state_d = W_IDLE;
		endcase
	end

	always_comb begin
		load_w = 1'b0;
		kind_w = TK_ERROR;
		val_w  = '0;
		pop_w  = 1'b0;
		push_w = 1'b0;
		last_w = 1'b0;
		done   = 1'b0;
		case (state_q)
			W_ERR: begin
				load_w = free_w;
				last_w = 1'b1;
				done   = free_w;
			end
			W_COST: begin
				load_w = free_w;
				kind_w = TK_COST;
				val_w  = cost_q;
			end
			W_EM: begin
				load_w = free_w;
				if (ti_q >= tj_q) begin
					kind_w = TK_MATRIX;
					val_w  = {{(COST_W-5){1'b0}}, {1'b0, ti_q} + 5'd1};
					pop_w  = 1'b1;
				end else if (tph_q == PH_OPEN) begin
					kind_w = TK_OPEN;
					push_w = 1'b1;
				end else if (tph_q == PH_TIMES) begin
					kind_w = TK_TIMES;
					push_w = 1'b1;
				end else begin
					kind_w = TK_CLOSE;
					pop_w  = 1'b1;
				end
				last_w = pop_w && (cnt_q == 6'd1);
				done   = free_w && last_w;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= W_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_w) ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		st_rd_q <= stack_mem[rd_a_w[STACK_AW-1:0]];
		if (load_w) begin
			okind_q <= kind_w;
			oval_q  <= val_w;
			olast_q <= last_w;
		end
		if (state_q == W_IDLE) begin
			cost_q <= cmd.cost;
			ti_q   <= '0;
			tj_q   <= cmd.last;
			tph_q  <= PH_OPEN;
			cnt_q  <= 6'd1;
		end
		if ((state_q == W_EM) && free_w) begin
			if (push_w) begin
				// park the current frame one phase on, descend into a half
				stack_mem[wr_a_w[STACK_AW-1:0]] <=
					{tph_q + 2'd1, tj_q, ti_q};
				cnt_q <= cnt_q + 6'd1;
				tph_q <= PH_OPEN;
				if (tph_q == PH_OPEN) begin
					tj_q <= sp_rdata;
				end else begin
					ti_q <= sp_rdata + 4'd1;
				end
			end else if (pop_w) begin
				cnt_q <= cnt_q - 6'd1;
				ti_q  <= st_rd_q[3:0];
				tj_q  <= st_rd_q[7:4];
				tph_q <= st_rd_q[9:8];
			end
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {4'b0, oval_q};
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;

endmodule

// ----- hw/rtl/matrix_chain_order_unit.sv -----
// Loading takes one cycle per dimension beat in T_LOAD; the final beat starts the
// fill or walk. Fill uses one shared multiply-add-compare unit: per subchain two
// reads, a multiply, per split point a read, multiply and add-compare, and a write.
// Walk: a read and an emit per token, held on output stalls; one item at a time.
// Reset clears the sequencers, dimension count and overflow flag; tables need none.
module matrix_chain_order_unit #(
	parameter int MAX_MATRICES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // dimension
	input  logic        s_tlast,  // final_dim
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // token_value
	output logic [2:0]  m_tuser,  // token_kind
	output logic        m_tlast   // run_end
);
	import mco_pkg::*;

	localparam int AW = $clog2(MAX_MATRICES + 1);
	localparam int CW = $clog2(MAX_MATRICES + 2);

	top_state_t state_q, state_d;

	logic [CW-1:0]     count_q;
	logic              ovf_q;
	logic [SIDE_W-1:0] nl_q;

	logic              acc_w, we_w, fin_w, err_w, one_w;
	logic [CW-1:0]     cnt_eff_w, nl_wide_w;
	logic              fill_start_w, fill_done_w;
	logic [COST_W-1:0] fill_cost_w;
	walk_cmd_t         cmd_w;
	logic              walk_done_w;
	logic [2*SIDE_W-1:0] sp_raddr_w;
	logic [SIDE_W-1:0] sp_rdata_w;

	assign s_tready  = (state_q == T_LOAD);
	assign acc_w     = s_tvalid && s_tready;
	assign we_w      = acc_w && (count_q < CW'(MAX_MATRICES + 1));
	assign fin_w     = acc_w && s_tlast;
	assign cnt_eff_w = count_q + (we_w ? CW'(1) : CW'(0));
	assign nl_wide_w = cnt_eff_w - CW'(2);
	assign err_w     = ovf_q || !we_w || (cnt_eff_w < CW'(2));
	assign one_w     = (cnt_eff_w == CW'(2));

	always_comb begin
		state_d = state_q;
		case (state_q)
			T_LOAD: begin
				if (fin_w) state_d = (err_w || one_w) ? T_WALK : T_FILL;
			end
			T_FILL: if (fill_done_w) state_d = T_WALK;
			T_WALK: if (walk_done_w) state_d = T_LOAD;
			default: state_d = T_LOAD;
		endcase
	end

	always_comb begin
		fill_start_w = 1'b0;
		cmd_w.go     = 1'b0;
		cmd_w.err    = 1'b0;
		cmd_w.cost   = '0;
		cmd_w.last   = nl_q;
		case (state_q)
			T_LOAD: begin
				if (fin_w) begin
					cmd_w.err    = err_w;
					cmd_w.go     = !err_w && one_w;
					cmd_w.last   = '0;
					fill_start_w = !err_w && !one_w;
				end
			end
			T_FILL: begin
				cmd_w.go   = fill_done_w;
				cmd_w.cost = fill_cost_w;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_w) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (acc_w) begin
				if (we_w) count_q <= cnt_eff_w;
				else ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_w) nl_q <= nl_wide_w[SIDE_W-1:0];
	end

	mco_fill #(
		.MAX_MATRICES(MAX_MATRICES),
		.AW(AW)
	) u_fill (
		.clk(clk),
		.arst_n(arst_n),
		.dim_we(we_w),
		.dim_waddr(count_q[AW-1:0]),
		.dim_wdata(s_tdata),
		.start(fill_start_w),
		.n_last(nl_wide_w[SIDE_W-1:0]),
		.done(fill_done_w),
		.best_cost(fill_cost_w),
		.sp_raddr(sp_raddr_w),
		.sp_rdata(sp_rdata_w)
	);

	mco_walk u_walk (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_w),
		.done(walk_done_w),
		.sp_raddr(sp_raddr_w),
		.sp_rdata(sp_rdata_w),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule
